// File: rtl/core/recursive_lock_fifo_handoff_core_macros.svh
// ----------------------------------------------------------------------------
// Recursive lock unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_LOCK_FIFO_HANDOFF_CORE_MACROS_SVH
`define RECURSIVE_LOCK_FIFO_HANDOFF_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RLFH_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define RLFH_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: rtl/core/rlfh_pkg.sv
// ----------------------------------------------------------------------------
// Recursive lock unit package
// Operation and status codes, sizes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlfh_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);

    localparam logic [1:0] OP_LOCK    = 2'd0;
    localparam logic [1:0] OP_TRYLOCK = 2'd1;
    localparam logic [1:0] OP_UNLOCK  = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [2:0] ST_ACQUIRED = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_TRYFAIL  = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_HANDOFF  = 3'd4;
    localparam logic [2:0] ST_OWNS     = 3'd5;
    localparam logic [2:0] ST_NOTOWNER = 3'd6;
    localparam logic [2:0] ST_ERROR    = 3'd7;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  woken_thread;
        logic        owner_valid;
        logic [7:0]  owner_thread;
        logic [15:0] depth_after;
    } rsp_t;

    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [7:0] enq_data;
    } queue_ctl_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [7:0] head_data;
    } queue_stat_t;

endpackage

// File: rtl/core/rlfh_req_if.sv
// ----------------------------------------------------------------------------
// Lock request channel
// Valid/ready channel carrying one lock request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rlfh_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] thread_id;

    modport source (output valid, output operation, output thread_id, input ready);
    modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

// File: rtl/core/rlfh_rsp_if.sv
// ----------------------------------------------------------------------------
// Lock result channel
// Valid/ready channel carrying one lock result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rlfh_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  woken_thread;
    logic        owner_valid;
    logic [7:0]  owner_thread;
    logic [15:0] depth_after;

    modport source (output valid, output status, output woken_thread, output owner_valid,
                    output owner_thread, output depth_after, input ready);
    modport sink   (input valid, input status, input woken_thread, input owner_valid,
                    input owner_thread, input depth_after, output ready);
endinterface

// File: rtl/core/rlfh_queue.sv
// ----------------------------------------------------------------------------
// Wait queue
// Circular FIFO of waiting thread identifiers with head, tail and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlfh_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlfh_pkg::queue_ctl_t ctl,
    output rlfh_pkg::queue_stat_t stat
);

    logic [7:0]                 slot_reg [rlfh_pkg::WAIT_DEPTH];
    logic [7:0]                 head_data_reg;
    logic [rlfh_pkg::PTR_W-1:0] head_reg;
    logic [rlfh_pkg::PTR_W-1:0] head_next;
    logic [rlfh_pkg::PTR_W-1:0] tail_reg;
    logic [rlfh_pkg::PTR_W-1:0] tail_next;
    logic [rlfh_pkg::CNT_W-1:0] count_reg;
    logic [rlfh_pkg::CNT_W-1:0] count_next;

    function automatic logic [rlfh_pkg::PTR_W-1:0] ptr_inc(
        input logic [rlfh_pkg::PTR_W-1:0] p
    );
        if (p == rlfh_pkg::PTR_W'(rlfh_pkg::WAIT_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign stat.full      = (count_reg == rlfh_pkg::CNT_W'(rlfh_pkg::WAIT_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.head_data = head_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.enq)
        begin
            tail_next = ptr_inc(tail_reg);
        end
        if (ctl.deq)
        begin
            head_next = ptr_inc(head_reg);
        end
        if (ctl.enq && !ctl.deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.deq && !ctl.enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // prefetch the next head entry; forward a write that lands in the next head slot
    always_ff @(posedge clk)
    begin
        if (ctl.enq)
        begin
            slot_reg[tail_reg] <= ctl.enq_data;
        end
        if (ctl.enq && (tail_reg == head_next))
        begin
            head_data_reg <= ctl.enq_data;
        end
        else
        begin
            head_data_reg <= slot_reg[head_next];
        end
    end

endmodule

// File: rtl/core/rlfh_engine.sv
// ----------------------------------------------------------------------------
// Lock engine
// Ownership state and per-request decision logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlfh_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  rlfh_pkg::req_t        req,
    input  rlfh_pkg::queue_stat_t qstat,
    output rlfh_pkg::queue_ctl_t  qctl,
    output rlfh_pkg::rsp_t        result
);

    logic [7:0]  owner_id_reg;
    logic [7:0]  owner_id_next;
    logic        owner_held_reg;
    logic        owner_held_next;
    logic [15:0] hold_depth_reg;
    logic [15:0] hold_depth_next;
    logic [2:0]  status;
    logic [7:0]  woken;
    logic        enq;
    logic        deq;
    logic        grantable;
    logic        overflow;

    assign grantable = !owner_held_reg || (owner_id_reg == req.thread_id);
    assign overflow  = (hold_depth_reg >= rlfh_pkg::DEPTH_MAX);

    always_comb
    begin
        owner_id_next   = owner_id_reg;
        owner_held_next = owner_held_reg;
        hold_depth_next = hold_depth_reg;
        status          = rlfh_pkg::ST_ERROR;
        woken           = '0;
        enq             = 1'b0;
        deq             = 1'b0;
        case (req.operation)
            rlfh_pkg::OP_LOCK, rlfh_pkg::OP_TRYLOCK:
            begin
                if (grantable)
                begin
                    if (!overflow)
                    begin
                        owner_id_next   = req.thread_id;
                        owner_held_next = 1'b1;
                        hold_depth_next = hold_depth_reg + 1'b1;
                        status          = rlfh_pkg::ST_ACQUIRED;
                    end
                end
                else if (req.operation == rlfh_pkg::OP_TRYLOCK)
                begin
                    status = rlfh_pkg::ST_TRYFAIL;
                end
                else if (!qstat.full)
                begin
                    enq    = 1'b1;
                    status = rlfh_pkg::ST_QUEUED;
                end
            end
            rlfh_pkg::OP_UNLOCK:
            begin
                if (owner_held_reg)
                begin
                    if (hold_depth_reg <= 16'd1)
                    begin
                        if (!qstat.empty)
                        begin
                            deq             = 1'b1;
                            owner_id_next   = qstat.head_data;
                            hold_depth_next = 16'd1;
                            woken           = qstat.head_data;
                            status          = rlfh_pkg::ST_HANDOFF;
                        end
                        else
                        begin
                            owner_held_next = 1'b0;
                            owner_id_next   = '0;
                            hold_depth_next = '0;
                            status          = rlfh_pkg::ST_FREED;
                        end
                    end
                    else
                    begin
                        hold_depth_next = hold_depth_reg - 1'b1;
                        status          = rlfh_pkg::ST_ACQUIRED;
                    end
                end
            end
            default:
            begin
                status = (owner_held_reg && owner_id_reg == req.thread_id) ?
                         rlfh_pkg::ST_OWNS : rlfh_pkg::ST_NOTOWNER;
            end
        endcase
    end

    assign qctl.enq      = fire && enq;
    assign qctl.deq      = fire && deq;
    assign qctl.enq_data = req.thread_id;

    assign result.status       = status;
    assign result.woken_thread = woken;
    assign result.owner_valid  = owner_held_next;
    assign result.owner_thread = owner_held_next ? owner_id_next : 8'd0;
    assign result.depth_after  = owner_held_next ? hold_depth_next : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_id_reg   <= '0;
            owner_held_reg <= 1'b0;
            hold_depth_reg <= '0;
        end
        else if (fire)
        begin
            owner_id_reg   <= owner_id_next;
            owner_held_reg <= owner_held_next;
            hold_depth_reg <= hold_depth_next;
        end
    end

endmodule

// File: rtl/core/recursive_lock_fifo_handoff_core.sv
// ----------------------------------------------------------------------------
// Recursive lock unit with FIFO handoff
// One recursive mutex: lock, trylock, unlock and ownership query requests,
// waiters held in a FIFO and handed ownership on the last unlock.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | operation[1:0], thread_id[7:0]
//  rsp     | out | status[2:0], woken_thread[7:0], owner_valid,
//          |     | owner_thread[7:0], depth_after[15:0]
//
//  One request per cycle unless the result channel stalls; a request's result
//  enters the result register when that register is free or being accepted.
//  Ownership state and the wait queue update as a request enters the result
//  register. Reset frees the lock and empties the queue at once.
//  A stalled result holds in the result register; the input register keeps
//  accepting as long as the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recursive_lock_fifo_handoff_core
(
    input  logic clk,
    input  logic rst_n,
    rlfh_req_if.sink   req,
    rlfh_rsp_if.source rsp
);

    logic                  s1_valid_reg;
    rlfh_pkg::req_t        s1_req_reg;
    logic                  out_valid_reg;
    rlfh_pkg::rsp_t        out_reg;
    logic                  advance;
    rlfh_pkg::queue_ctl_t  qctl;
    rlfh_pkg::queue_stat_t qstat;
    rlfh_pkg::rsp_t        result;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    rlfh_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .stat  (qstat)
    );

    rlfh_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .req    (s1_req_reg),
        .qstat  (qstat),
        .qctl   (qctl),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg.operation <= req.operation;
            s1_req_reg.thread_id <= req.thread_id;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.woken_thread = out_reg.woken_thread;
    assign rsp.owner_valid  = out_reg.owner_valid;
    assign rsp.owner_thread = out_reg.owner_thread;
    assign rsp.depth_after  = out_reg.depth_after;

endmodule

// File: rtl/core/rlfh_checker.sv
// ----------------------------------------------------------------------------
// Recursive lock unit checker
// Port-level checks on result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "recursive_lock_fifo_handoff_core_macros.svh"

module rlfh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [7:0]  woken_thread,
    input logic        owner_valid,
    input logic [7:0]  owner_thread,
    input logic [15:0] depth_after
);

    `RLFH_ASSERT_IMPLY(a_woken_only_on_handoff, clk, rst_n, rsp_valid && status != rlfh_pkg::ST_HANDOFF, woken_thread == 8'd0)
    `RLFH_ASSERT_IMPLY(a_free_reads_zero, clk, rst_n, rsp_valid && !owner_valid, owner_thread == 8'd0 && depth_after == 16'd0)
    `RLFH_ASSERT_IMPLY(a_handoff_owner, clk, rst_n, rsp_valid && status == rlfh_pkg::ST_HANDOFF, owner_valid && owner_thread == woken_thread && depth_after == 16'd1)
    `RLFH_ASSERT_NEXT(a_stall_holds, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(owner_thread) && $stable(depth_after))

endmodule

bind recursive_lock_fifo_handoff_core rlfh_checker u_rlfh_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .woken_thread (rsp.woken_thread),
    .owner_valid  (rsp.owner_valid),
    .owner_thread (rsp.owner_thread),
    .depth_after  (rsp.depth_after)
);

// File: tb/tb_recursive_lock_fifo_handoff_core.sv
// ----------------------------------------------------------------------------
// Recursive lock unit testbench
// Drives lock, trylock, unlock and query requests through the request
// channel and checks every result, field by field and in order, against a
// built-in model of the lock owner, hold depth and FIFO of waiters, or for
// typed rows against the table's own values. The request table comes first,
// then random bursts with random stalls on both channels, one stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_recursive_lock_fifo_handoff_core;

    localparam int RAND_REQS   = 730;
    localparam int IDLE_PCT    = 34;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [1:0]     op;
        logic [7:0]     tid;
        bit             typed;
        rlfh_pkg::rsp_t rsp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rlfh_req_if req ();
    rlfh_rsp_if rsp ();

    recursive_lock_fifo_handoff_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // lock model state
    logic [7:0]     lk_owner;
    logic           lk_held;
    logic [15:0]    lk_depth;
    logic [7:0]     waiters [rlfh_pkg::WAIT_DEPTH];
    int             wq_head;
    int             wq_tail;
    int             wq_count;

    rlfh_pkg::rsp_t pending_rsp [$];
    int             fail_count  = 0;
    int             stall_count = 0;
    bit             no_idle     = 1'b0;
    dir_row_t       dir_tab [15];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rlfh_pkg::rsp_t lock_step(logic [1:0] op, logic [7:0] tid);
        rlfh_pkg::rsp_t r;
        logic can_grant;
        r = '0;
        r.status = rlfh_pkg::ST_ERROR;
        can_grant = !lk_held || lk_owner == tid;
        case (op)
            rlfh_pkg::OP_LOCK, rlfh_pkg::OP_TRYLOCK:
            begin
                if (can_grant)
                begin
                    if (lk_depth != rlfh_pkg::DEPTH_MAX)
                    begin
                        lk_owner = tid;
                        lk_held  = 1'b1;
                        lk_depth = lk_depth + 16'd1;
                        r.status = rlfh_pkg::ST_ACQUIRED;
                    end
                end
                else if (op == rlfh_pkg::OP_TRYLOCK)
                    r.status = rlfh_pkg::ST_TRYFAIL;
                else if (wq_count < rlfh_pkg::WAIT_DEPTH)
                begin
                    waiters[wq_tail] = tid;
                    wq_tail  = (wq_tail + 1) % rlfh_pkg::WAIT_DEPTH;
                    wq_count = wq_count + 1;
                    r.status = rlfh_pkg::ST_QUEUED;
                end
            end
            rlfh_pkg::OP_UNLOCK:
            begin
                if (!lk_held)
                    r.status = rlfh_pkg::ST_ERROR;
                else if (lk_depth <= 16'd1)
                begin
                    if (wq_count > 0)
                    begin
                        lk_owner = waiters[wq_head];
                        wq_head  = (wq_head + 1) % rlfh_pkg::WAIT_DEPTH;
                        wq_count = wq_count - 1;
                        lk_depth = 16'd1;
                        r.woken_thread = lk_owner;
                        r.status = rlfh_pkg::ST_HANDOFF;
                    end
                    else
                    begin
                        lk_held  = 1'b0;
                        lk_owner = 8'd0;
                        lk_depth = 16'd0;
                        r.status = rlfh_pkg::ST_FREED;
                    end
                end
                else
                begin
                    lk_depth = lk_depth - 16'd1;
                    r.status = rlfh_pkg::ST_ACQUIRED;
                end
            end
            default:
                r.status = (lk_held && lk_owner == tid) ?
                           rlfh_pkg::ST_OWNS : rlfh_pkg::ST_NOTOWNER;
        endcase
        r.owner_valid  = lk_held;
        r.owner_thread = lk_held ? lk_owner : 8'd0;
        r.depth_after  = lk_held ? lk_depth : 16'd0;
        return r;
    endfunction

    function automatic dir_row_t dir_row(logic [1:0] op, logic [7:0] tid, bit typed,
                                         logic [2:0] st, logic [7:0] woken, logic ov,
                                         logic [7:0] own, logic [15:0] dep);
        dir_row_t d;
        d.op    = op;
        d.tid   = tid;
        d.typed = typed;
        d.rsp   = '{status: st, woken_thread: woken, owner_valid: ov,
                    owner_thread: own, depth_after: dep};
        return d;
    endfunction

    task automatic send_req(logic [1:0] op, logic [7:0] tid, bit typed,
                            rlfh_pkg::rsp_t typed_rsp);
        rlfh_pkg::rsp_t pred;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.thread_id <= tid;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = lock_step(op, tid);
        pending_rsp.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic send(logic [1:0] op, logic [7:0] tid);
        send_req(op, tid, 1'b0, '0);
    endtask

    // response side stalls
    always @(posedge clk)
        rsp.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        rlfh_pkg::rsp_t got;
        rlfh_pkg::rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{status: rsp.status, woken_thread: rsp.woken_thread,
                    owner_valid: rsp.owner_valid, owner_thread: rsp.owner_thread,
                    depth_after: rsp.depth_after};
            if (pending_rsp.size() == 0)
            begin
                $error("result with no request waiting: status %0d", got.status);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.woken_thread !== want.woken_thread)
                begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.woken_thread, got.woken_thread);
                    fail_count++;
                end
                if (got.owner_valid !== want.owner_valid)
                begin
                    $error("owner_valid: expected %0d, got %0d",
                           want.owner_valid, got.owner_valid);
                    fail_count++;
                end
                if (got.owner_thread !== want.owner_thread)
                begin
                    $error("owner_thread: expected %0d, got %0d",
                           want.owner_thread, got.owner_thread);
                    fail_count++;
                end
                if (got.depth_after !== want.depth_after)
                begin
                    $error("depth_after: expected %0d, got %0d",
                           want.depth_after, got.depth_after);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_count = 0;
            else
                stall_count = stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int         kind;
        int         n;
        int         rand_count;
        logic [7:0] pool [4];
        logic [1:0] op;
        logic [7:0] tid;

        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.operation = rlfh_pkg::OP_LOCK;
        req.thread_id = 8'd0;
        rsp.ready     = 1'b0;

        lk_owner = 8'd0;
        lk_held  = 1'b0;
        lk_depth = 16'd0;
        wq_head  = 0;
        wq_tail  = 0;
        wq_count = 0;

        dir_tab = '{
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd0, 1'b1,
                    rlfh_pkg::ST_ERROR, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_QUERY, 8'd0, 1'b1,
                    rlfh_pkg::ST_NOTOWNER, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_TRYLOCK, 8'd255, 1'b1,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b1, 8'd255, 16'd1),
            dir_row(rlfh_pkg::OP_LOCK, 8'd255, 1'b1,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b1, 8'd255, 16'd2),
            dir_row(rlfh_pkg::OP_QUERY, 8'd255, 1'b1,
                    rlfh_pkg::ST_OWNS, 8'd0, 1'b1, 8'd255, 16'd2),
            dir_row(rlfh_pkg::OP_TRYLOCK, 8'd0, 1'b1,
                    rlfh_pkg::ST_TRYFAIL, 8'd0, 1'b1, 8'd255, 16'd2),
            dir_row(rlfh_pkg::OP_LOCK, 8'd0, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_LOCK, 8'd170, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_LOCK, 8'd0, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd85, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd255, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd0, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd170, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_UNLOCK, 8'd0, 1'b0,
                    rlfh_pkg::ST_ACQUIRED, 8'd0, 1'b0, 8'd0, 16'd0),
            dir_row(rlfh_pkg::OP_QUERY, 8'd255, 1'b1,
                    rlfh_pkg::ST_NOTOWNER, 8'd0, 1'b0, 8'd0, 16'd0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].op, dir_tab[i].tid, dir_tab[i].typed, dir_tab[i].rsp);

        rand_count = 0;
        while (rand_count < RAND_REQS)
        begin
            // run a stretch at full rate on both sides
            no_idle = (rand_count >= RAND_REQS / 3) && (rand_count < RAND_REQS / 2);
            foreach (pool[i])
                pool[i] = 8'($urandom);
            kind = $urandom_range(9);
            if (kind < 5)
            begin
                n = $urandom_range(30, 10);
                repeat (n)
                begin
                    op  = 2'($urandom_range(3));
                    tid = ($urandom_range(4) == 0) ? 8'($urandom) : pool[$urandom_range(3)];
                    send(op, tid);
                end
            end
            else if (kind < 8)
            begin
                // load the wait queue near or past full, then drain it
                send(rlfh_pkg::OP_LOCK, pool[0]);
                n = $urandom_range(rlfh_pkg::WAIT_DEPTH + 3, rlfh_pkg::WAIT_DEPTH - 4);
                repeat (n)
                begin
                    tid = ($urandom_range(3) == 0) ? 8'($urandom) : pool[$urandom_range(3, 1)];
                    op  = ($urandom_range(7) == 0) ? rlfh_pkg::OP_TRYLOCK : rlfh_pkg::OP_LOCK;
                    send(op, tid);
                end
                rand_count = rand_count + n + 1;
                n = n + 2;
                repeat (n)
                begin
                    op = ($urandom_range(5) == 0) ? rlfh_pkg::OP_QUERY : rlfh_pkg::OP_UNLOCK;
                    send(op, pool[$urandom_range(3)]);
                end
            end
            else
            begin
                n = $urandom_range(15, 5);
                repeat (n)
                    send(2'($urandom_range(3)), 8'($urandom));
            end
            rand_count = rand_count + n;
        end
        no_idle = 1'b0;
        req.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
